@@ rtl/page_table_builder_walker_macros.svh @@
// Assertion macros used by the page table builder and walker controller.
`ifndef PAGE_TABLE_BUILDER_WALKER_MACROS_SVH
`define PAGE_TABLE_BUILDER_WALKER_MACROS_SVH
`ifndef SYNTHESIS
`define PTBW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PTBW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PTBW_ASSERT_IMP(lbl, ante, cons)
`define PTBW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/ptbw_pkg.sv @@
// Shared types, codes and constants of the page table builder and walker.
package ptbw_pkg;
   localparam int VIRT_BITS  = 39;
   localparam int PHYS_BITS  = 56;
   localparam int ENTRY_W    = 64;
   localparam int PPN_W      = 44;
   localparam int PAGE_SHIFT = 12;
   localparam int VPN_W      = 9;
   localparam int OP_W       = 2;
   localparam int MODE_W     = 3;
   localparam int CNT_W      = 16;
   localparam int STAT_W     = 3;
   localparam int LVL_W      = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [LVL_W-1:0] LVL_TOP = 2'd2;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_XLATE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_USER_NOEXEC = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RT_NOEXEC   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RT_FULL     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_USER_FULL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNTRUSTED   = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STAT_W-1:0] ST_MAPPED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_MODE = 3'd2;
   localparam logic [STAT_W-1:0] ST_BEYOND   = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_TABLE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ENCLAVE_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNTRUSTED_BASE = 2'd1;

   localparam logic [7:0] PTE_V = 8'h01;
   localparam logic [7:0] PTE_R = 8'h02;
   localparam logic [7:0] PTE_W = 8'h04;
   localparam logic [7:0] PTE_X = 8'h08;
   localparam logic [7:0] PTE_U = 8'h10;
   localparam logic [7:0] PTE_A = 8'h40;
   localparam logic [7:0] PTE_D = 8'h80;

   localparam logic [PHYS_BITS-1:0] PAGE_BYTES = 56'd4096;
   localparam logic [VIRT_BITS-1:0] VPAGE_BYTES = 39'd4096;

   typedef struct packed {
      logic clr_wr;
      logic load;
      logic rd;
      logic take;
      logic mk_table;
      logic fin_nt;
      logic fin_xlate;
      logic fin_mapped;
      logic alloc;
      logic fin_beyond;
      logic descend;
      logic next_page;
   } cmd_type;

   typedef struct packed {
      logic            clr_last;
      logic [OP_W-1:0] op;
      logic            cnt_zero;
      logic            all_done;
      logic            ent_valid;
      logic            lvl_zero;
      logic            lvl_one;
      logic            in_store;
   } stat_type;

   function automatic logic [7:0] mode_flags(input logic [MODE_W-1:0] mode);
      logic [7:0] f;
      case (mode)
         MODE_USER_NOEXEC: f = PTE_D | PTE_A | PTE_R | PTE_W | PTE_U | PTE_V;
         MODE_RT_NOEXEC:   f = PTE_D | PTE_A | PTE_R | PTE_W | PTE_V;
         MODE_RT_FULL:     f = PTE_D | PTE_A | PTE_R | PTE_W | PTE_X | PTE_V;
         MODE_USER_FULL:   f = PTE_D | PTE_A | PTE_R | PTE_W | PTE_X | PTE_U | PTE_V;
         MODE_UNTRUSTED:   f = PTE_D | PTE_A | PTE_R | PTE_W | PTE_V;
         default:          f = 8'h00;
      endcase
      return f;
   endfunction
endpackage

@@ rtl/ptbw_req_if.sv @@
// Request channel interface of the page table builder and walker.
interface ptbw_req_if;
   import ptbw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [VIRT_BITS-1:0]   virt_addr;
   logic [MODE_W-1:0]      map_mode;
   logic [PHYS_BITS-1:0]   source_addr;
   logic [CNT_W-1:0]       page_count;
   modport source (output valid, operation, virt_addr, map_mode, source_addr, page_count,
                   input ready);
   modport sink (input valid, operation, virt_addr, map_mode, source_addr, page_count,
                 output ready);
endinterface

@@ rtl/ptbw_rsp_if.sv @@
// Response channel interface of the page table builder and walker.
interface ptbw_rsp_if;
   import ptbw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [PHYS_BITS-1:0] page_addr;
   logic                 copy_request;
   logic [PHYS_BITS-1:0] copy_source;
   logic [CNT_W-1:0]     pages_done;
   modport source (output valid, status, page_addr, copy_request, copy_source, pages_done,
                   input ready);
   modport sink (input valid, status, page_addr, copy_request, copy_source, pages_done,
                 output ready);
endinterface

@@ rtl/ptbw_csr_if.sv @@
// Configuration write channel interface of the page table builder and walker.
interface ptbw_csr_if;
   import ptbw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [PHYS_BITS-1:0] write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

@@ rtl/page_table_builder_walker.sv @@
// Top level of the Sv39 page table builder and walker.
// The block builds and walks a three-level page table kept in an on-chip entry store.
// Requests arrive on req_chan: allocate maps a virtual page to a fresh data page,
// translate returns the leaf address, and reserve builds tables for a run of pages.
// Each request yields exactly one response on rsp_chan.
// Configuration writes on csr_chan set the enclave and untrusted bases and reload
// the free pointers; they are always accepted and are to be issued while idle.
// After reset the store is cleared one entry per cycle, all STORE_PAGES * 512 entries;
// no request is accepted during that pass.
// One request is handled at a time. Each upper table level takes a store read, an entry
// update and a bounds check, and the leaf level a store read and an entry update; a walk
// that stops before the leaf level responds sooner. The next request can be taken in
// the cycle after the response is accepted.
// The response stays valid until rsp_chan.ready is high; no new request is taken
// while it waits.
module page_table_builder_walker #(
   parameter int STORE_PAGES = 64
) (
   input logic         clock,
   input logic         reset,
   ptbw_req_if.sink    req_chan,
   ptbw_rsp_if.source  rsp_chan,
   ptbw_csr_if.sink    csr_chan
);
   import ptbw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_chan.ready = 1'b1;

   ptbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptbw_dpath #(
      .STORE_PAGES (STORE_PAGES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_chan.operation),
      .req_virt_addr    (req_chan.virt_addr),
      .req_map_mode     (req_chan.map_mode),
      .req_source_addr  (req_chan.source_addr),
      .req_page_count   (req_chan.page_count),
      .csr_write        (csr_chan.valid),
      .csr_reg_index    (csr_chan.reg_index),
      .csr_write_data   (csr_chan.write_data),
      .rsp_status       (rsp_chan.status),
      .rsp_page_addr    (rsp_chan.page_addr),
      .rsp_copy_request (rsp_chan.copy_request),
      .rsp_copy_source  (rsp_chan.copy_source),
      .rsp_pages_done   (rsp_chan.pages_done)
   );
endmodule

@@ rtl/ptbw_dpath.sv @@
// Datapath: entry store, free pointers, walk registers and response registers.
module ptbw_dpath #(
   parameter int STORE_PAGES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ptbw_pkg::cmd_type              cmd,
   output ptbw_pkg::stat_type             stat,
   input  logic [ptbw_pkg::OP_W-1:0]      req_operation,
   input  logic [ptbw_pkg::VIRT_BITS-1:0] req_virt_addr,
   input  logic [ptbw_pkg::MODE_W-1:0]    req_map_mode,
   input  logic [ptbw_pkg::PHYS_BITS-1:0] req_source_addr,
   input  logic [ptbw_pkg::CNT_W-1:0]     req_page_count,
   input  logic                           csr_write,
   input  logic [ptbw_pkg::CSR_IDX_W-1:0] csr_reg_index,
   input  logic [ptbw_pkg::PHYS_BITS-1:0] csr_write_data,
   output logic [ptbw_pkg::STAT_W-1:0]    rsp_status,
   output logic [ptbw_pkg::PHYS_BITS-1:0] rsp_page_addr,
   output logic                           rsp_copy_request,
   output logic [ptbw_pkg::PHYS_BITS-1:0] rsp_copy_source,
   output logic [ptbw_pkg::CNT_W-1:0]     rsp_pages_done
);
   import ptbw_pkg::*;

   localparam int DEPTH = STORE_PAGES * 512;
   localparam int AW    = $clog2(DEPTH);
   localparam int PG_W  = $clog2(STORE_PAGES);

   logic [ENTRY_W-1:0]   store_mem [DEPTH];
   logic [ENTRY_W-1:0]   rd_ff;
   logic [ENTRY_W-1:0]   ent_ff, ent_in;
   logic [AW-1:0]        clr_ff;
   logic [OP_W-1:0]      op_ff;
   logic [VIRT_BITS-1:0] va_ff, va_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [PHYS_BITS-1:0] src_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [PG_W-1:0]      pg_ff, pg_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [PHYS_BITS-1:0] enc_base_ff;
   logic [PHYS_BITS-1:0] enc_ptr_ff, enc_ptr_in;
   logic [PHYS_BITS-1:0] unt_ptr_ff, unt_ptr_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [PHYS_BITS-1:0] phys_ff, phys_in;
   logic                 copy_ff, copy_in;
   logic [PHYS_BITS-1:0] csrc_ff, csrc_in;

   logic [VPN_W-1:0]     vpn;
   logic [AW-1:0]        slot;
   logic [PHYS_BITS-1:0] ent_addr, rd_addr, diff;
   logic [PPN_W-1:0]     dpage;
   logic                 in_store;
   logic [ENTRY_W-1:0]   table_pte;
   logic [PPN_W-1:0]     leaf_ppn;
   logic [7:0]           flags;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [ENTRY_W-1:0]   mem_wd;

   always_comb begin
      case (lvl_ff)
         2'd2:    vpn = va_ff[38:30];
         2'd1:    vpn = va_ff[29:21];
         default: vpn = va_ff[20:12];
      endcase
   end

   assign slot      = {pg_ff, vpn};
   assign ent_addr  = {ent_ff[10 +: PPN_W], 12'h000};
   assign rd_addr   = {rd_ff[10 +: PPN_W], 12'h000};
   assign diff      = ent_addr - enc_base_ff;
   assign dpage     = diff[PHYS_BITS-1:PAGE_SHIFT];
   assign in_store  = (ent_addr >= enc_base_ff) && (dpage < PPN_W'(STORE_PAGES));
   assign table_pte = {10'h000, enc_ptr_ff[PHYS_BITS-1:PAGE_SHIFT], 2'b00, PTE_V};
   assign leaf_ppn  = (mode_ff == MODE_UNTRUSTED) ? unt_ptr_ff[PHYS_BITS-1:PAGE_SHIFT]
                                                  : enc_ptr_ff[PHYS_BITS-1:PAGE_SHIFT];
   assign flags     = mode_flags(mode_ff);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = slot;
      mem_wd = table_pte;
      if (cmd.clr_wr) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (cmd.mk_table) begin
         mem_we = 1'b1;
      end else if (cmd.alloc && flags[0]) begin
         mem_we = 1'b1;
         mem_wd = {10'h000, leaf_ppn, 2'b00, flags};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd) begin
         rd_ff <= store_mem[slot];
      end
   end

   always_comb begin
      ent_in     = ent_ff;
      va_in      = va_ff;
      done_in    = done_ff;
      pg_in      = pg_ff;
      lvl_in     = lvl_ff;
      enc_ptr_in = enc_ptr_ff;
      unt_ptr_in = unt_ptr_ff;
      status_in  = status_ff;
      phys_in    = phys_ff;
      copy_in    = copy_ff;
      csrc_in    = csrc_ff;
      if (cmd.load) begin
         va_in     = req_virt_addr;
         done_in   = '0;
         pg_in     = '0;
         lvl_in    = LVL_TOP;
         status_in = ST_DONE;
         phys_in   = '0;
         copy_in   = 1'b0;
         csrc_in   = '0;
      end
      if (cmd.take) begin
         ent_in = rd_ff;
      end
      if (cmd.mk_table) begin
         ent_in     = table_pte;
         enc_ptr_in = enc_ptr_ff + PAGE_BYTES;
      end
      if (cmd.descend) begin
         pg_in  = dpage[PG_W-1:0];
         lvl_in = lvl_ff - 2'd1;
      end
      if (cmd.next_page) begin
         done_in = done_ff + 16'd1;
         va_in   = va_ff + VPAGE_BYTES;
         pg_in   = '0;
         lvl_in  = LVL_TOP;
      end
      if (cmd.fin_nt) begin
         status_in = ST_NO_TABLE;
      end
      if (cmd.fin_beyond) begin
         status_in = ST_BEYOND;
      end
      if (cmd.fin_xlate) begin
         phys_in = rd_addr;
      end
      if (cmd.fin_mapped) begin
         status_in = ST_MAPPED;
         phys_in   = rd_addr;
      end
      if (cmd.alloc) begin
         if (mode_ff == MODE_UNTRUSTED) begin
            unt_ptr_in = unt_ptr_ff + PAGE_BYTES;
         end else begin
            enc_ptr_in = enc_ptr_ff + PAGE_BYTES;
         end
         if (flags[0]) begin
            phys_in = {leaf_ppn, 12'h000};
            if (mode_ff >= MODE_RT_FULL) begin
               copy_in = 1'b1;
               csrc_in = src_ff;
            end
         end else begin
            status_in = ST_BAD_MODE;
         end
      end
      if (csr_write && csr_reg_index == CSR_ENCLAVE_BASE) begin
         enc_ptr_in = csr_write_data + PAGE_BYTES;
      end
      if (csr_write && csr_reg_index == CSR_UNTRUSTED_BASE) begin
         unt_ptr_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         enc_base_ff <= '0;
         enc_ptr_ff  <= PAGE_BYTES;
         unt_ptr_ff  <= '0;
      end else begin
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_write && csr_reg_index == CSR_ENCLAVE_BASE) begin
            enc_base_ff <= csr_write_data;
         end
         enc_ptr_ff <= enc_ptr_in;
         unt_ptr_ff <= unt_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         mode_ff <= req_map_mode;
         src_ff  <= req_source_addr;
         cnt_ff  <= req_page_count;
      end
      ent_ff    <= ent_in;
      va_ff     <= va_in;
      done_ff   <= done_in;
      pg_ff     <= pg_in;
      lvl_ff    <= lvl_in;
      status_ff <= status_in;
      phys_ff   <= phys_in;
      copy_ff   <= copy_in;
      csrc_ff   <= csrc_in;
   end

   always_comb begin
      stat.clr_last  = (clr_ff == AW'(DEPTH - 1));
      stat.op        = op_ff;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.all_done  = (done_ff == cnt_ff);
      stat.ent_valid = rd_ff[0];
      stat.lvl_zero  = (lvl_ff == 2'd0);
      stat.lvl_one   = (lvl_ff == 2'd1);
      stat.in_store  = in_store;
   end

   assign rsp_status       = status_ff;
   assign rsp_page_addr    = phys_ff;
   assign rsp_copy_request = copy_ff;
   assign rsp_copy_source  = csrc_ff;
   assign rsp_pages_done   = done_ff;
endmodule

@@ rtl/ptbw_ctrl.sv @@
// Controller state machine that sequences store clearing, table walks and responses.
`include "page_table_builder_walker_macros.svh"
module ptbw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ptbw_pkg::stat_type stat,
   output ptbw_pkg::cmd_type  cmd
);
   import ptbw_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DISP  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_NEXT  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.op == OP_ALLOC || stat.op == OP_XLATE ||
                (stat.op == OP_RESERVE && !stat.cnt_zero)) begin
               state_in = S_READ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.lvl_zero) begin
               state_in = S_DONE;
               if (stat.op == OP_XLATE) begin
                  cmd.fin_xlate = 1'b1;
               end else if (stat.ent_valid) begin
                  cmd.fin_mapped = 1'b1;
               end else begin
                  cmd.alloc = 1'b1;
               end
            end else if (stat.ent_valid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end else if (stat.op == OP_XLATE) begin
               cmd.fin_nt = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.mk_table = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.in_store) begin
               cmd.fin_beyond = 1'b1;
               state_in       = S_DONE;
            end else if (stat.lvl_one && stat.op == OP_RESERVE) begin
               cmd.next_page = 1'b1;
               state_in      = S_NEXT;
            end else begin
               cmd.descend = 1'b1;
               state_in    = S_READ;
            end
         end
         S_NEXT: begin
            state_in = stat.all_done ? S_DONE : S_READ;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `PTBW_ASSERT_NXT(a_load_dispatch, req_valid && req_ready, state_ff == S_DISP)
   `PTBW_ASSERT_IMP(a_table_not_xlate, cmd.mk_table, stat.op != OP_XLATE && !stat.lvl_zero)
   `PTBW_ASSERT_IMP(a_alloc_at_leaf, cmd.alloc, stat.lvl_zero && stat.op == OP_ALLOC)
   `PTBW_ASSERT_IMP(a_descend_in_store, cmd.descend, stat.in_store && !stat.lvl_zero)
endmodule
